// ===== design/tsf_pkg.sv =====
// Package for the triangle scanline fill core.
// Holds widths, codes, state type and the controller/datapath bundles.
// No dependencies.
package tsf_pkg;

  localparam int COORD_W  = 13;
  localparam int CFG_W    = 12;
  localparam int SHADE_W  = 8;
  localparam int DY_W     = 13;  // edge height, never negative after sorting
  localparam int NUM_W    = 30;  // signed numerator x0*dy + dx*(y-y0)
  localparam int MAG_W    = NUM_W - 1;
  localparam int CNT_W    = $clog2(MAG_W);
  localparam int MAX_SCREEN_DEF = 2048;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = 12'd800;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 12'd800;

  localparam logic CFG_WIDTH_IDX  = 1'b0;
  localparam logic CFG_HEIGHT_IDX = 1'b1;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_STEP = 1'b1;

  localparam logic EDGE_START = 1'b0;
  localparam logic EDGE_STOP  = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_MUL1  = 5'b00010,
    ST_MUL2  = 5'b00100,
    ST_DIV   = 5'b01000,
    ST_WRITE = 5'b10000
  } tsf_state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic edge_sel;
    logic mul1;
    logic mul2;
    logic div_init;
    logic div_step;
    logic write;
  } tsf_cmd_t;

  typedef struct packed {
    logic busy;
    logic need_span;
    logic div_last;
  } tsf_status_t;

endpackage

// ===== design/tsf_ctrl.sv =====
// Controller of the triangle scanline fill core.
// Sequences span-end computation; depends on tsf_pkg.
module tsf_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_accept,
  input  logic                in_kind,
  input  tsf_pkg::tsf_status_t status,
  output tsf_pkg::tsf_cmd_t   cmd,
  output logic                idle
);

  tsf_pkg::tsf_state_t state_r, state_nxt;
  logic edge_r, edge_nxt;
  logic start_span;

  assign start_span = in_accept && ((in_kind == tsf_pkg::KIND_LOAD) ||
                      (status.busy && status.need_span));

  always_comb begin
    state_nxt = state_r;
    edge_nxt  = edge_r;
    case (state_r)
      tsf_pkg::ST_IDLE: begin
        if (start_span) begin
          state_nxt = tsf_pkg::ST_MUL1;
          edge_nxt  = tsf_pkg::EDGE_START;
        end
      end
      tsf_pkg::ST_MUL1:  state_nxt = tsf_pkg::ST_MUL2;
      tsf_pkg::ST_MUL2:  state_nxt = tsf_pkg::ST_DIV;
      tsf_pkg::ST_DIV: begin
        if (status.div_last) state_nxt = tsf_pkg::ST_WRITE;
      end
      tsf_pkg::ST_WRITE: begin
        if (edge_r == tsf_pkg::EDGE_START) begin
          edge_nxt  = tsf_pkg::EDGE_STOP;
          state_nxt = tsf_pkg::ST_MUL1;
        end else begin
          state_nxt = tsf_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tsf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tsf_pkg::ST_IDLE;
      edge_r  <= tsf_pkg::EDGE_START;
    end else begin
      state_r <= state_nxt;
      edge_r  <= edge_nxt;
    end
  end

  assign idle         = (state_r == tsf_pkg::ST_IDLE);
  assign cmd.load     = in_accept && (in_kind == tsf_pkg::KIND_LOAD);
  assign cmd.step     = in_accept && (in_kind == tsf_pkg::KIND_STEP);
  assign cmd.edge_sel = edge_r;
  assign cmd.mul1     = (state_r == tsf_pkg::ST_MUL1);
  assign cmd.mul2     = (state_r == tsf_pkg::ST_MUL2);
  assign cmd.div_init = (state_r == tsf_pkg::ST_MUL2);
  assign cmd.div_step = (state_r == tsf_pkg::ST_DIV);
  assign cmd.write    = (state_r == tsf_pkg::ST_WRITE);

endmodule

// ===== design/tsf_dp.sv =====
// Datapath of the triangle scanline fill core: corners, walk state,
// span-end multiply/divide and the result register; depends on tsf_pkg.
module tsf_dp #(
  parameter int MAX_SCREEN = tsf_pkg::MAX_SCREEN_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  tsf_pkg::tsf_cmd_t                   cmd,
  output tsf_pkg::tsf_status_t                status,
  input  logic                                cfg_we,
  input  logic                                cfg_index,
  input  logic [tsf_pkg::CFG_W-1:0]           cfg_data,
  input  logic signed [tsf_pkg::COORD_W-1:0]  in_vert_a_x,
  input  logic signed [tsf_pkg::COORD_W-1:0]  in_vert_a_y,
  input  logic signed [tsf_pkg::COORD_W-1:0]  in_vert_b_x,
  input  logic signed [tsf_pkg::COORD_W-1:0]  in_vert_b_y,
  input  logic signed [tsf_pkg::COORD_W-1:0]  in_vert_c_x,
  input  logic signed [tsf_pkg::COORD_W-1:0]  in_vert_c_y,
  input  logic [tsf_pkg::SHADE_W-1:0]         in_shade,
  input  logic                                out_stall,
  output logic                                out_valid,
  output logic signed [tsf_pkg::COORD_W-1:0]  out_pixel_x,
  output logic signed [tsf_pkg::COORD_W-1:0]  out_pixel_y,
  output logic [tsf_pkg::SHADE_W-1:0]         out_pixel_shade,
  output logic                                out_write_enable,
  output logic                                out_last_pixel
);

  localparam int CW = tsf_pkg::COORD_W;
  localparam int NW = tsf_pkg::NUM_W;
  localparam int MW = tsf_pkg::MAG_W;
  localparam int DW = tsf_pkg::DY_W;
  localparam logic [CW-1:0] MAX_LIM = CW'(MAX_SCREEN);

  logic [tsf_pkg::CFG_W-1:0] width_r, height_r;
  logic signed [CW-1:0] ax_r, ay_r, bx_r, by_r, cx_r, cy_r;
  logic signed [CW-1:0] row_r, col_r, stop_r;
  logic lower_r, busy_r;
  logic [tsf_pkg::SHADE_W-1:0] shade_r;

  logic signed [NW-1:0] prod_r, num_r;
  logic [DW-1:0] rem_r;
  logic [MW-1:0] quo_r;
  logic neg_r;
  logic [tsf_pkg::CNT_W-1:0] cnt_r;

  logic out_valid_r, out_we_r, out_last_r;
  logic signed [CW-1:0] out_x_r, out_y_r;
  logic [tsf_pkg::SHADE_W-1:0] out_shade_r;

  // sort network
  logic signed [CW-1:0] sx0, sy0, sx1, sy1, sx2, sy2, tx, ty;
  always_comb begin
    sx0 = in_vert_a_x; sy0 = in_vert_a_y;
    sx1 = in_vert_b_x; sy1 = in_vert_b_y;
    sx2 = in_vert_c_x; sy2 = in_vert_c_y;
    if (sy0 > sy1) begin
      tx = sx0; ty = sy0; sx0 = sx1; sy0 = sy1; sx1 = tx; sy1 = ty;
    end
    if (sy0 > sy2) begin
      tx = sx0; ty = sy0; sx0 = sx2; sy0 = sy2; sx2 = tx; sy2 = ty;
    end
    if (sy1 > sy2) begin
      tx = sx1; ty = sy1; sx1 = sx2; sy1 = sy2; sx2 = tx; sy2 = ty;
    end
    tx = sx0; ty = sy0;
  end

  // edge endpoints
  logic signed [CW-1:0] e_x0, e_y0, e_x1, e_y1;
  always_comb begin
    if (cmd.edge_sel == tsf_pkg::EDGE_STOP) begin
      e_x0 = ax_r; e_y0 = ay_r; e_x1 = cx_r; e_y1 = cy_r;
    end else if (lower_r) begin
      e_x0 = bx_r; e_y0 = by_r; e_x1 = cx_r; e_y1 = cy_r;
    end else begin
      e_x0 = ax_r; e_y0 = ay_r; e_x1 = bx_r; e_y1 = by_r;
    end
  end

  logic signed [CW:0] dy_s, dx_s, dr_s;
  logic [DW-1:0] dy_u;
  assign dy_s = {e_y1[CW-1], e_y1} - {e_y0[CW-1], e_y0};
  assign dx_s = {e_x1[CW-1], e_x1} - {e_x0[CW-1], e_x0};
  assign dr_s = {row_r[CW-1], row_r} - {e_y0[CW-1], e_y0};
  assign dy_u = dy_s[DW-1:0];

  logic signed [2*CW+1:0] mul_a, mul_b;
  assign mul_a = e_x0 * dy_s;
  assign mul_b = dx_s * dr_s;

  // restoring divide step
  logic [DW:0] rem_sh;
  logic [DW:0] rem_sub;
  logic        q_bit;
  assign rem_sh  = {rem_r, quo_r[MW-1]};
  assign rem_sub = rem_sh - {1'b0, dy_u};
  assign q_bit   = (rem_sh >= {1'b0, dy_u});

  logic signed [MW:0] q_signed;
  logic signed [CW-1:0] edge_val;
  assign q_signed = neg_r ? -$signed({1'b0, quo_r}) : $signed({1'b0, quo_r});
  assign edge_val = (dy_u == '0) ? e_x0 : q_signed[CW-1:0];

  // walk
  logic at_stop, row_lt_b, row_lt_c;
  assign at_stop  = (col_r == stop_r);
  assign row_lt_b = (row_r < by_r);
  assign row_lt_c = (row_r < cy_r);

  logic [CW-1:0] w_lim, h_lim;
  assign w_lim = ({1'b0, width_r}  > MAX_LIM) ? MAX_LIM : {1'b0, width_r};
  assign h_lim = ({1'b0, height_r} > MAX_LIM) ? MAX_LIM : {1'b0, height_r};

  logic on_screen, emit;
  assign on_screen = !col_r[CW-1] && ($unsigned(col_r) < w_lim) &&
                     !row_r[CW-1] && ($unsigned(row_r) < h_lim);
  assign emit = cmd.step && busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= tsf_pkg::WIDTH_RESET;
      height_r <= tsf_pkg::HEIGHT_RESET;
    end else if (cfg_we) begin
      if (cfg_index == tsf_pkg::CFG_WIDTH_IDX) width_r <= cfg_data;
      else height_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ax_r <= '0; ay_r <= '0; bx_r <= '0; by_r <= '0; cx_r <= '0; cy_r <= '0;
      row_r <= '0; col_r <= '0; stop_r <= '0;
      lower_r <= 1'b0; busy_r <= 1'b0; shade_r <= '0;
    end else if (cmd.load) begin
      ax_r <= tx;  ay_r <= ty;
      bx_r <= sx1; by_r <= sy1;
      cx_r <= sx2; cy_r <= sy2;
      row_r <= ty; lower_r <= 1'b0; busy_r <= 1'b1; shade_r <= in_shade;
    end else if (emit) begin
      if (!at_stop) begin
        col_r <= (col_r < stop_r) ? col_r + 1'b1 : col_r - 1'b1;
      end else if (!lower_r) begin
        if (row_lt_b) row_r <= row_r + 1'b1;
        else begin
          lower_r <= 1'b1;
          row_r   <= by_r;
        end
      end else if (row_lt_c) begin
        row_r <= row_r + 1'b1;
      end else begin
        busy_r <= 1'b0;
      end
    end else if (cmd.write) begin
      if (cmd.edge_sel == tsf_pkg::EDGE_STOP) stop_r <= edge_val;
      else col_r <= edge_val;
    end
  end

  // multiply and divide
  always_ff @(posedge clk) begin
    if (cmd.mul1) prod_r <= NW'(mul_a);
    if (cmd.mul2) num_r  <= prod_r + NW'(mul_b);
    if (cmd.div_step && cnt_r == '0) begin
      neg_r <= num_r[NW-1];
      quo_r <= num_r[NW-1] ? MW'(-num_r) : num_r[MW-1:0];
      rem_r <= '0;
    end else if (cmd.div_step) begin
      rem_r <= q_bit ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
      quo_r <= {quo_r[MW-2:0], q_bit};
    end
  end

  // counts the divider setup step, then MW divide steps
  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= '0;
    else if (cmd.div_init) cnt_r <= '0;
    else if (cmd.div_step) cnt_r <= cnt_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (emit) out_valid_r <= 1'b1;
    else if (!out_stall) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_x_r     <= col_r;
      out_y_r     <= row_r;
      out_shade_r <= shade_r;
      out_we_r    <= on_screen;
      out_last_r  <= lower_r && (row_r == cy_r) && at_stop;
    end
  end

  assign status.busy      = busy_r;
  assign status.need_span = at_stop && (!lower_r || row_lt_c);
  assign status.div_last  = (cnt_r == tsf_pkg::CNT_W'(MW));

  assign out_valid        = out_valid_r;
  assign out_pixel_x      = out_x_r;
  assign out_pixel_y      = out_y_r;
  assign out_pixel_shade  = out_shade_r;
  assign out_write_enable = out_we_r;
  assign out_last_pixel   = out_last_r;

endmodule

// ===== design/triangle_scanline_fill_core.sv =====
// Top level of the triangle scanline fill core.
// Joins tsf_ctrl and tsf_dp; depends on tsf_pkg.
//
// Usage:
//  - Input channel (in_valid/in_stall): kind 0 loads a triangle (three
//    vertices and a shade), kind 1 is a step tick. A load gives no result;
//    a step while a triangle is active gives one pixel request on the
//    output channel, a step while idle gives nothing.
//  - Output channel (out_valid/out_stall): one registered pixel request,
//    shown the cycle after the step is taken.
//  - Configuration (cfg_we/cfg_index/cfg_data): index 0 screen width,
//    index 1 screen height; write only while idle.
//  - A step inside a span does not raise in_stall. A load, and a step that
//    ends a row other than the last, start the span-end computation: per
//    edge the states MUL1 and MUL2, a divider setup step, 29 restoring divide
//    steps and a write, for both ends in turn, with in_stall high throughout.
//  - The divider is a single serial unit shared by both span ends.
//  - Reset: synchronous, active low; idle, no triangle, screen 800 x 800.
//  - When out_stall holds a pending request, in_stall rises and holds off
//    further input until the request is taken.
module triangle_scanline_fill_core #(
  parameter int MAX_SCREEN = tsf_pkg::MAX_SCREEN_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_kind,
  input  logic signed [tsf_pkg::COORD_W-1:0]  in_vert_a_x,
  input  logic signed [tsf_pkg::COORD_W-1:0]  in_vert_a_y,
  input  logic signed [tsf_pkg::COORD_W-1:0]  in_vert_b_x,
  input  logic signed [tsf_pkg::COORD_W-1:0]  in_vert_b_y,
  input  logic signed [tsf_pkg::COORD_W-1:0]  in_vert_c_x,
  input  logic signed [tsf_pkg::COORD_W-1:0]  in_vert_c_y,
  input  logic [tsf_pkg::SHADE_W-1:0]         in_shade,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [tsf_pkg::COORD_W-1:0]  out_pixel_x,
  output logic signed [tsf_pkg::COORD_W-1:0]  out_pixel_y,
  output logic [tsf_pkg::SHADE_W-1:0]         out_pixel_shade,
  output logic                                out_write_enable,
  output logic                                out_last_pixel,
  input  logic                                cfg_we,
  input  logic                                cfg_index,
  input  logic [tsf_pkg::CFG_W-1:0]           cfg_data
);

  tsf_pkg::tsf_cmd_t    cmd;
  tsf_pkg::tsf_status_t status;
  logic idle, in_accept;

  // hold input while a span is computed or a request waits downstream
  assign in_stall  = !idle || (out_valid && out_stall);
  assign in_accept = in_valid && !in_stall;

  tsf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .in_kind   (in_kind),
    .status    (status),
    .cmd       (cmd),
    .idle      (idle)
  );

  tsf_dp #(.MAX_SCREEN(MAX_SCREEN)) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .status           (status),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_vert_a_x      (in_vert_a_x),
    .in_vert_a_y      (in_vert_a_y),
    .in_vert_b_x      (in_vert_b_x),
    .in_vert_b_y      (in_vert_b_y),
    .in_vert_c_x      (in_vert_c_x),
    .in_vert_c_y      (in_vert_c_y),
    .in_shade         (in_shade),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_pixel_x      (out_pixel_x),
    .out_pixel_y      (out_pixel_y),
    .out_pixel_shade  (out_pixel_shade),
    .out_write_enable (out_write_enable),
    .out_last_pixel   (out_last_pixel)
  );

endmodule
